### hw/rtl/bed_pkg.sv
// bed_pkg: shared types and constants of the button event detector
// holds the per-button state word, event and configuration types
// no dependencies
package bed_pkg;

  // field widths
  localparam int unsigned TickW     = 32;
  localparam int unsigned BtnW      = 3;
  localparam int unsigned CodeW     = 3;
  localparam int unsigned ActW      = 4;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned MaxEvents = 3;
  localparam int unsigned NumCand   = 5;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 40;

  // event codes on the output stream
  typedef enum logic [CodeW-1:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_DOUBLE  = 3'd2,
    EV_TRIPLE  = 3'd3,
    EV_HOLD    = 3'd4,
    EV_REPEAT  = 3'd5
  } event_code_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOLD_TICKS   = 3'd0,
    CFG_REPEAT_TICKS = 3'd1,
    CFG_CLICK_WINDOW = 3'd2,
    CFG_IDLE_LEVEL   = 3'd3,
    CFG_ACTIVE_BTNS  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [TickW-1:0] hold_ticks;
    logic [TickW-1:0] repeat_ticks;
    logic [TickW-1:0] click_window;
    logic             idle_level;
    logic [ActW-1:0]  active_buttons;
  } cfg_t;

  // one state word per button
  typedef struct packed {
    logic             prev_level;
    logic [TickW-1:0] press_time;
    logic [TickW-1:0] repeat_time;
    logic [TickW-1:0] last_press;
    logic [1:0]       click_count;
    logic             hold_active;
    logic             pressed_before;
  } btn_state_t;

  localparam btn_state_t StateReset = '{prev_level: 1'b1, default: '0};

  typedef struct packed {
    logic [BtnW-1:0]  button;
    event_code_e      code;
    logic [TickW-1:0] held;
    logic             last;
  } event_t;

  // up to three events caused by one sample, in emission order
  typedef struct packed {
    logic [1:0]              num;
    event_t [MaxEvents-1:0]  ev;
  } event_bundle_t;

endpackage

### hw/rtl/bed_state_mem.sv
// bed_state_mem: per-button state memory with registered read
// valid bits give the reset state of unwritten entries; write-to-read bypass
// depends on bed_pkg
module bed_state_mem import bed_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = 8,
  parameter int unsigned IdxW        = 3
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output btn_state_t      rd_data_o,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  btn_state_t      wr_data_i
);

  btn_state_t             mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] valid_q;
  btn_state_t             rd_q;
  logic                   rd_valid_q;
  logic                   byp_q;
  btn_state_t             byp_data_q;

  // storage array and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q       <= mem[rd_addr_i];
      byp_data_q <= wr_data_i;
    end
  end

  // entry valid bits and read-side control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
        byp_q      <= wr_en_i && (wr_addr_i == rd_addr_i);
      end
    end
  end

  // a write in the read cycle wins over the stale array word
  always_comb begin
    if (byp_q) begin
      rd_data_o = byp_data_q;
    end else if (rd_valid_q) begin
      rd_data_o = rd_q;
    end else begin
      rd_data_o = StateReset;
    end
  end

endmodule

### hw/rtl/bed_update.sv
// bed_update: edge, click and hold decisions for one sample
// produces the next state word and the ordered events of the sample
// depends on bed_pkg
module bed_update import bed_pkg::*; (
  input  btn_state_t       state_i,
  input  cfg_t             cfg_i,
  input  logic [BtnW-1:0]  button_i,
  input  logic             level_i,
  input  logic [TickW-1:0] now_i,
  output btn_state_t       state_o,
  output event_bundle_t    bundle_o
);

  logic             changed, pressed_edge, released_edge, not_idle;
  logic [TickW-1:0] elapsed, repeat_base;
  logic             hold_due, repeat_due, fire_hold, fire_repeat;
  logic             multi_click, fire_double, fire_triple;
  logic [1:0]       click_inc;
  logic [NumCand-1:0] cand_v;
  event_code_e      cand_code [NumCand];
  logic [TickW-1:0] cand_held [NumCand];
  logic [1:0]       n;

  // edges against the stored level
  assign changed       = level_i != state_i.prev_level;
  assign not_idle      = level_i != cfg_i.idle_level;
  assign pressed_edge  = changed && not_idle;
  assign released_edge = changed && !not_idle;

  // ticks since the (possibly new) press time
  always_comb begin
    if (pressed_edge) begin
      elapsed = '0;
    end else if (released_edge) begin
      elapsed = now_i;
    end else begin
      elapsed = now_i - state_i.press_time;
    end
  end

  assign repeat_base = released_edge ? '0 : state_i.repeat_time;
  assign hold_due    = not_idle && (elapsed >= cfg_i.hold_ticks);
  assign repeat_due  = (now_i - repeat_base) >= cfg_i.repeat_ticks;
  assign fire_hold   = hold_due && !state_i.hold_active;
  assign fire_repeat = hold_due && state_i.hold_active && repeat_due;

  // multi-click counting
  assign multi_click = pressed_edge && state_i.pressed_before &&
                       ((now_i - state_i.last_press) < cfg_i.click_window);
  assign click_inc   = state_i.click_count + 2'd1;
  assign fire_double = multi_click && (click_inc == 2'd1);
  assign fire_triple = multi_click && (click_inc == 2'd2);

  // next state word
  always_comb begin
    state_o            = state_i;
    state_o.prev_level = level_i;
    if (pressed_edge) begin
      state_o.press_time     = now_i;
      state_o.last_press     = now_i;
      state_o.pressed_before = 1'b1;
      if (!multi_click || fire_triple) begin
        state_o.click_count = 2'd0;
      end else begin
        state_o.click_count = click_inc;
      end
    end
    if (released_edge) begin
      state_o.press_time  = '0;
      state_o.repeat_time = '0;
      state_o.hold_active = 1'b0;
    end
    if (fire_hold || fire_repeat) begin
      state_o.repeat_time = now_i;
    end
    if (fire_hold) begin
      state_o.hold_active = 1'b1;
    end
  end

  // candidate events in emission order
  always_comb begin
    cand_v       = {fire_repeat, fire_hold, released_edge, pressed_edge,
                    fire_double || fire_triple};
    cand_code[0] = fire_triple ? EV_TRIPLE : EV_DOUBLE;
    cand_code[1] = EV_PRESS;
    cand_code[2] = EV_RELEASE;
    cand_code[3] = EV_HOLD;
    cand_code[4] = EV_REPEAT;
    cand_held[0] = '0;
    cand_held[1] = '0;
    cand_held[2] = '0;
    cand_held[3] = elapsed;
    cand_held[4] = elapsed;
  end

  // pack the fired candidates into consecutive slots
  always_comb begin
    n        = '0;
    bundle_o = '0;
    for (int i = 0; i < NumCand; i++) begin
      if (cand_v[i] && (n != 2'(MaxEvents))) begin
        bundle_o.ev[n].button = button_i;
        bundle_o.ev[n].code   = cand_code[i];
        bundle_o.ev[n].held   = cand_held[i];
        n = n + 2'd1;
      end
    end
    for (int j = 0; j < MaxEvents; j++) begin
      bundle_o.ev[j].last = (2'(j) == (n - 2'd1));
    end
    bundle_o.num = n;
  end

endmodule

### hw/rtl/bed_event_fifo.sv
// bed_event_fifo: four-entry event queue feeding the output stream
// takes up to three events per cycle, hands out one per transaction
// depends on bed_pkg
module bed_event_fifo import bed_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  event_bundle_t       push_i,
  output logic                room_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // event_button, event_code, held_ticks
  output logic                m_axis_tlast    // last_event
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  event_t          entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            pop;
  event_t          head;

  assign pop    = m_axis_tvalid && m_axis_tready;
  assign room_o = count_q <= (PtrW+1)'(Depth - MaxEvents);
  assign head   = entry_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + (PtrW+1)'(push_i.num) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry writes, one slot per pushed event
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxEvents; k++) begin
      if (2'(k) < push_i.num) begin
        entry_q[wr_ptr_q + PtrW'(k)] <= push_i.ev[k];
      end
    end
  end

  // output side
  assign m_axis_tvalid = count_q != '0;
  assign m_axis_tdata  = {(OutDataW - BtnW - CodeW - TickW)'(0), head.held, head.code,
                          head.button};
  assign m_axis_tlast  = head.last;

endmodule

### hw/rtl/button_event_detector.sv
// button_event_detector: top level of the button click and hold event detector
// instantiates bed_state_mem, bed_update and bed_event_fifo; depends on bed_pkg
//
// Each sample (button index, pin level, tick count) reads the button's state
// word from a synchronous memory in the cycle it is accepted, is evaluated in
// the next cycle and written back as it leaves the update stage, and its up to
// three events go into a small queue for the output stream. A new sample can be
// accepted every cycle unless the update stage is stalled; the memory bypass covers
// samples of the same button in consecutive cycles. The sustained rate is set by
// the output stream, which moves one event per transaction, and the queue stalls
// the update stage only while it holds more than one event. Samples of buttons
// outside the active range cause no state change and no event. State comes out of
// reset cleared through per-entry valid bits, with no clearing pass.
module button_event_detector import bed_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [TickW-1:0]    cfg_wdata_i,
  // sample stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // button_index, level, now
  // event stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // event_button, event_code, held_ticks
  output logic                m_axis_tlast    // last_event
);

  localparam int unsigned IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int unsigned LimW = $clog2(NUM_BUTTONS + 1) + ActW;

  cfg_t             cfg_q;
  logic             accept, in_active, s1_fire, fifo_room;
  logic [BtnW-1:0]  in_button;
  logic             in_level;
  logic [TickW-1:0] in_now;
  logic [LimW-1:0]  limit;
  logic             s1_valid_q, s1_active_q, s1_level_q;
  logic [BtnW-1:0]  s1_button_q;
  logic [TickW-1:0] s1_now_q;
  btn_state_t       rd_state, new_state;
  event_bundle_t    bundle, push;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_ticks     <= TickW'(100);
      cfg_q.repeat_ticks   <= TickW'(50);
      cfg_q.click_window   <= TickW'(30);
      cfg_q.idle_level     <= 1'b1;
      cfg_q.active_buttons <= ActW'(8);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_HOLD_TICKS:   cfg_q.hold_ticks     <= cfg_wdata_i;
        CFG_REPEAT_TICKS: cfg_q.repeat_ticks   <= cfg_wdata_i;
        CFG_CLICK_WINDOW: cfg_q.click_window   <= cfg_wdata_i;
        CFG_IDLE_LEVEL:   cfg_q.idle_level     <= cfg_wdata_i[0];
        CFG_ACTIVE_BTNS:  cfg_q.active_buttons <= cfg_wdata_i[ActW-1:0];
        default: ;
      endcase
    end
  end

  // input unpacking and active range check
  assign in_button = s_axis_tdata[BtnW-1:0];
  assign in_level  = s_axis_tdata[BtnW];
  assign in_now    = s_axis_tdata[BtnW+TickW:BtnW+1];

  always_comb begin
    if (LimW'(cfg_q.active_buttons) > LimW'(NUM_BUTTONS)) begin
      limit = LimW'(NUM_BUTTONS);
    end else begin
      limit = LimW'(cfg_q.active_buttons);
    end
  end

  assign in_active     = LimW'(in_button) < limit;
  assign s1_fire       = s1_valid_q && fifo_room;
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // update stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // update stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_active_q <= in_active;
      s1_button_q <= in_button;
      s1_level_q  <= in_level;
      s1_now_q    <= in_now;
    end
  end

  bed_state_mem #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .IdxW        (IdxW)
  ) u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && in_active),
    .rd_addr_i (IdxW'(in_button)),
    .rd_data_o (rd_state),
    .wr_en_i   (s1_fire && s1_active_q),
    .wr_addr_i (IdxW'(s1_button_q)),
    .wr_data_i (new_state)
  );

  bed_update u_update (
    .state_i  (rd_state),
    .cfg_i    (cfg_q),
    .button_i (s1_button_q),
    .level_i  (s1_level_q),
    .now_i    (s1_now_q),
    .state_o  (new_state),
    .bundle_o (bundle)
  );

  // only active samples leaving the stage push events
  always_comb begin
    push = bundle;
    if (!(s1_fire && s1_active_q)) begin
      push.num = '0;
    end
  end

  bed_event_fifo u_event_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .room_o        (fifo_room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  // a stalled sample keeps its place and payload
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> (s1_valid_q && $stable(s1_now_q) &&
                                  $stable(s1_button_q)))
    else $error("update stage lost a stalled sample");

  // events of one sample are queued together, so a non-last event is followed
  a_burst_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
    else $error("event burst broken before its last event");

  // events appear only after an active sample left the update stage
  a_event_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s1_fire && s1_active_q))
    else $error("event without an active sample");
`endif

endmodule
